// ===== sv/cpn_pkg.sv =====
// cpn_pkg: shared types, constants and helpers for capped_position_nudge.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpn_pkg;

  localparam int unsigned SQRT_STEPS = 32;          // one root bit per cell
  localparam int unsigned QW         = 13;          // step magnitude <= cap
  localparam int unsigned NUMW       = 45;          // |d| * cap
  localparam int unsigned DENW       = 48;          // N * root
  localparam int unsigned LATENCY    = 50;          // start to done, cycles

  localparam logic [QW-1:0] CAP_Q20 = 13'd5243;     // 0.005 m in Q11.20
  localparam logic [63:0]   CAP_SQ  = 64'd27489049; // CAP_Q20 squared

  typedef struct packed {
    logic               nudge_enable;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic               body_last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               was_capped;
    logic               out_last;
  } out_t;

  // Sideband that rides along the cell chains.
  typedef struct packed {
    logic             valid;
    logic             en;
    logic             last;
    logic             capped;
    logic [2:0]       neg;
    logic [2:0][31:0] cur;
    logic [2:0][31:0] mag;
  } side_t;

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    logic [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -33'sh0_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cpn_sqrt_cell.sv =====
// cpn_sqrt_cell: one digit step of the integer square root chain.
// Depends on cpn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpn_sqrt_cell import cpn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [63:0] rad_in,
  input  wire logic [33:0] rem_in,
  input  wire logic [31:0] root_in,
  input  wire side_t       side_in,
  output logic      [63:0] rad_out,
  output logic      [33:0] rem_out,
  output logic      [31:0] root_out,
  output side_t            side_out
);

  logic [35:0] t;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    t     = {rem_in, rad_in[63:62]};
    trial = {2'b00, root_in, 2'b01};
    ge    = (t >= trial);
  end

  always_ff @(posedge clk) begin
    rad_out  <= {rad_in[61:0], 2'b00};
    rem_out  <= ge ? 34'(t - trial) : t[33:0];
    root_out <= {root_in[30:0], ge};
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out <= side_in;
    end
  end

endmodule
`default_nettype wire

// ===== sv/cpn_div_cell.sv =====
// cpn_div_cell: one quotient bit of the restoring divider chain, three axes.
// Depends on cpn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpn_div_cell import cpn_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [2:0][NUMW-1:0] num_in,
  input  wire logic [2:0][QW-1:0]   q_in,
  input  wire logic [DENW-1:0]      den_in,
  input  wire side_t                side_in,
  output logic      [2:0][NUMW-1:0] num_out,
  output logic      [2:0][QW-1:0]   q_out,
  output logic      [DENW-1:0]      den_out,
  output side_t                     side_out
);

  localparam int unsigned CW = DENW + QW;

  logic [CW-1:0]   dsh;
  logic [2:0]      ge;
  logic [2:0][NUMW-1:0] num_next;
  logic [2:0][QW-1:0]   q_next;

  always_comb begin
    dsh = CW'(den_in) << SHIFT;
    for (int i = 0; i < 3; i++) begin
      ge[i]       = (CW'(num_in[i]) >= dsh);
      num_next[i] = ge[i] ? NUMW'(CW'(num_in[i]) - dsh) : num_in[i];
      q_next[i]        = q_in[i];
      q_next[i][SHIFT] = ge[i];
    end
  end

  always_ff @(posedge clk) begin
    num_out  <= num_next;
    q_out    <= q_next;
    den_out  <= den_in;
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out <= side_in;
    end
  end

endmodule
`default_nettype wire

// ===== sv/capped_position_nudge.sv =====
// capped_position_nudge: fully pipelined position nudge with step cap.
// One body accepted every cycle; busy stays low.
// Pipeline depth is dominated by the 32-cell square root chain and the 13-cell divider chain.
// Sync reset clears all pipeline valid bits and sets frames_to_converge to 1.
// done pulses for one cycle per beat; the receiver cannot stall it.
// Depends on cpn_pkg, cpn_sqrt_cell, cpn_div_cell.
`timescale 1ns / 1ps
`default_nettype none
module capped_position_nudge import cpn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_t         item,
  output logic             done,
  output out_t             result,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  // frames_to_converge; the user must write it only while idle, the block does not enforce this
  logic [15:0] frames;
  logic [15:0] n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames <= 16'd1;
    end else if (cfg_we) begin
      frames <= cfg_wdata;
    end
  end

  assign n_eff = (frames == 16'd0) ? 16'd1 : frames;
  assign busy  = 1'b0;

  // Stage 1: saturated delta per axis
  logic             s1_valid, s1_en, s1_last;
  logic [2:0][31:0] s1_cur, s1_d;
  logic [2:0][31:0] cur_in, goal_in;

  assign cur_in  = {item.cur_z, item.cur_y, item.cur_x};
  assign goal_in = {item.goal_z, item.goal_y, item.goal_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
    s1_en    <= item.nudge_enable;
    s1_last  <= item.body_last;
    for (int i = 0; i < 3; i++) begin
      s1_cur[i] <= cur_in[i];
      s1_d[i]   <= sat32(33'(signed'(goal_in[i])) - 33'(signed'(cur_in[i])));
    end
  end

  // Stage 2: magnitudes and squares
  side_t            s2_side;
  logic [2:0][63:0] s2_sq;
  logic [2:0][31:0] mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = s1_d[i][31] ? 32'(32'd0 - s1_d[i]) : s1_d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.valid <= 1'b0;
    end else begin
      s2_side.valid <= s1_valid;
    end
    s2_side.en     <= s1_en;
    s2_side.last   <= s1_last;
    s2_side.capped <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      s2_side.neg[i] <= s1_d[i][31];
      s2_side.cur[i] <= s1_cur[i];
      s2_side.mag[i] <= mag[i];
      s2_sq[i]       <= 64'(mag[i]) * 64'(mag[i]);
    end
  end

  // Stage 3: squared length and the cap decision (3 * 2^62 fits in 64 bits)
  side_t       s3_side;
  side_t       s3_next;
  logic [63:0] s3_l2;
  logic [63:0] l2;

  assign l2 = s2_sq[0] + s2_sq[1] + s2_sq[2];

  always_comb begin
    s3_next        = s2_side;
    s3_next.capped = s2_side.en && (l2 > CAP_SQ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side.valid <= 1'b0;
    end else begin
      s3_side <= s3_next;
    end
    s3_l2 <= l2;
  end

  // Square root chain: each cell settles one root bit
  logic  [63:0] sq_rad  [SQRT_STEPS+1];
  logic  [33:0] sq_rem  [SQRT_STEPS+1];
  logic  [31:0] sq_root [SQRT_STEPS+1];
  side_t        sq_side [SQRT_STEPS+1];

  assign sq_rad[0]  = s3_l2;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s3_side;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    cpn_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .rad_in   (sq_rad[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .side_in  (sq_side[g]),
      .rad_out  (sq_rad[g+1]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .side_out (sq_side[g+1])
    );
  end

  // Multiply stage: capped divides |d|*cap by N*root, else |d| by N
  side_t                m_side;
  logic [2:0][NUMW-1:0] m_num;
  logic [DENW-1:0]      m_den;
  side_t                sqo;

  assign sqo = sq_side[SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_side.valid <= 1'b0;
    end else begin
      m_side <= sqo;
    end
    m_den  <= sqo.capped ? DENW'(n_eff) * DENW'(sq_root[SQRT_STEPS]) : DENW'(n_eff);
    for (int i = 0; i < 3; i++) begin
      m_num[i] <= sqo.capped ? NUMW'(sqo.mag[i]) * NUMW'(CAP_Q20) : NUMW'(sqo.mag[i]);
    end
  end

  // Divider chain: on enabled beats the quotient never exceeds the cap, so QW bits suffice
  logic [2:0][NUMW-1:0] dv_num  [QW+1];
  logic [2:0][QW-1:0]   dv_q    [QW+1];
  logic [DENW-1:0]      dv_den  [QW+1];
  side_t                dv_side [QW+1];

  assign dv_num[0]  = m_num;
  assign dv_q[0]    = '0;
  assign dv_den[0]  = m_den;
  assign dv_side[0] = m_side;

  for (genvar g = 0; g < QW; g++) begin : g_div
    cpn_div_cell #(.SHIFT(QW - 1 - g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .num_in   (dv_num[g]),
      .q_in     (dv_q[g]),
      .den_in   (dv_den[g]),
      .side_in  (dv_side[g]),
      .num_out  (dv_num[g+1]),
      .q_out    (dv_q[g+1]),
      .den_out  (dv_den[g+1]),
      .side_out (dv_side[g+1])
    );
  end

  // Output stage: signed step added to position, saturated; position passes through when disabled
  side_t            dvo;
  logic [2:0][31:0] new_pos;
  logic signed [32:0] step;

  assign dvo = dv_side[QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step = dvo.neg[i] ? -33'(signed'({1'b0, dv_q[QW][i]})) : 33'(signed'({1'b0, dv_q[QW][i]}));
      new_pos[i] = dvo.en ? sat32(33'(signed'(dvo.cur[i])) + step) : dvo.cur[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvo.valid;
    end
    result.new_x      <= new_pos[0];
    result.new_y      <= new_pos[1];
    result.new_z      <= new_pos[2];
    result.was_capped <= dvo.capped;
    result.out_last   <= dvo.last;
  end

endmodule
`default_nettype wire

// ===== sv/cpn_checker.sv =====
// cpn_props: port-level assertions for capped_position_nudge, with bind.
// Depends on cpn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpn_props import cpn_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire out_t result
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done right after reset");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("done without matching start");

  a_cap_only_on_done: assert property (@(posedge clk) disable iff (rst)
    done && result.was_capped |-> $past(start, LATENCY) && !$past(rst, LATENCY))
    else $error("capped beat without start");

endmodule

bind capped_position_nudge cpn_props u_cpn_props (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
